[sv/oah_pkg.sv]
package oah_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS    = 31;

  localparam int SLOT_BITS = $clog2(TABLE_DEPTH);
  // active size runs 1..TABLE_DEPTH, so one bit more than a slot index
  localparam int SIZE_BITS = SLOT_BITS + 1;

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 5;

  // remainder is formed two key bits per step, MSB first
  localparam int DIV_STEPS = (KEY_BITS + 1) / 2;
  localparam int DIV_BITS  = 2 * DIV_STEPS;
  localparam int DIV_CNT_BITS = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PROBE_MODE = 1'd0,
    CFG_TABLE_SIZE = 1'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_HOME   = 2'd0,
    ST_PROBED = 2'd1,
    ST_DROP   = 2'd2
  } status_t;

  typedef struct packed {
    logic    load;
    logic    div_step;
    logic    probe_init;
    logic    probe_step;
    logic    finish;
    status_t code;
  } oah_cmd_t;

  typedef struct packed {
    logic div_last;
    logic home_full;
    logic cand_full;
    logic probes_out;
  } oah_stat_t;

endpackage

[sv/oah_ctrl.sv]
module oah_ctrl
  import oah_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  oah_stat_t stat,
  output oah_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_HOME,
    S_PROBE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.code  = ST_DROP;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_HOME;
      end
      S_HOME: begin
        if (!stat.home_full) begin
          cmd.finish = 1'b1;
          cmd.code   = ST_HOME;
          state_nxt  = S_IDLE;
        end else begin
          cmd.probe_init = 1'b1;
          state_nxt      = S_PROBE;
        end
      end
      S_PROBE: begin
        if (stat.probes_out) begin
          cmd.finish = 1'b1;
          cmd.code   = ST_DROP;
          state_nxt  = S_IDLE;
        end else if (!stat.cand_full) begin
          cmd.finish = 1'b1;
          cmd.code   = ST_PROBED;
          state_nxt  = S_IDLE;
        end else begin
          cmd.probe_step = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

[sv/oah_dp.sv]
module oah_dp
  import oah_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic [KEY_BITS-1:0]      in_key,
  input  logic                     in_batch_end,
  input  oah_cmd_t                 cmd,
  output oah_stat_t                stat,
  output logic                     out_strobe,
  output logic [1:0]               out_status,
  output logic [SLOT_BITS-1:0]     out_slot,
  output logic                     out_batch_end_out
);

  // v < 2n in every use, so one conditional subtract reduces it mod n
  function automatic logic [SIZE_BITS-1:0] mod_sub(input logic [SIZE_BITS-1:0] v,
                                                   input logic [SIZE_BITS-1:0] n);
    mod_sub = (v >= n) ? (v - n) : v;
  endfunction

  logic                     mode_r;
  logic [CFG_DATA_BITS-1:0] tsize_r;

  logic [KEY_BITS-1:0]      key_r;
  logic                     be_r;
  logic [DIV_BITS-1:0]      div_sh_r;
  logic [DIV_CNT_BITS-1:0]  div_cnt_r;
  logic [SLOT_BITS-1:0]     rem_r;
  logic [SLOT_BITS-1:0]     idx_r;
  logic [SLOT_BITS-1:0]     inc_r;
  logic [SIZE_BITS-1:0]     j_r;
  logic [TABLE_DEPTH-1:0]   full_r;
  logic [KEY_BITS-1:0]      slot_keys_mem [TABLE_DEPTH];

  logic                     strobe_r;
  status_t                  status_r;
  logic [SLOT_BITS-1:0]     slot_r;
  logic                     be_out_r;

  logic [SIZE_BITS-1:0]     n_act;
  logic [SIZE_BITS-1:0]     r1, r2;
  logic [SIZE_BITS-1:0]     cand;
  logic [SIZE_BITS-1:0]     inc1, inc2, inc_init;
  logic [SLOT_BITS-1:0]     slot_sel;

  always_comb begin
    if (tsize_r == '0) begin
      n_act = SIZE_BITS'(1);
    end else if (SIZE_BITS'(tsize_r) > SIZE_BITS'(TABLE_DEPTH)) begin
      n_act = SIZE_BITS'(TABLE_DEPTH);
    end else begin
      n_act = SIZE_BITS'(tsize_r);
    end
  end

  // two restoring remainder steps per cycle
  assign r1 = mod_sub({rem_r, div_sh_r[DIV_BITS-1]}, n_act);
  assign r2 = mod_sub({r1[SLOT_BITS-1:0], div_sh_r[DIV_BITS-2]}, n_act);

  assign cand     = mod_sub({1'b0, idx_r} + {1'b0, inc_r}, n_act);
  assign inc1     = mod_sub({1'b0, inc_r} + SIZE_BITS'(1), n_act);
  assign inc2     = mod_sub(inc1 + SIZE_BITS'(1), n_act);
  assign inc_init = mod_sub(SIZE_BITS'(1), n_act);

  assign stat.div_last   = (div_cnt_r == DIV_CNT_BITS'(DIV_STEPS - 1));
  assign stat.home_full  = full_r[rem_r];
  assign stat.cand_full  = full_r[cand[SLOT_BITS-1:0]];
  assign stat.probes_out = (j_r >= n_act);

  always_comb begin
    case (cmd.code)
      ST_HOME:   slot_sel = rem_r;
      ST_PROBED: slot_sel = cand[SLOT_BITS-1:0];
      default:   slot_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      tsize_r  <= CFG_DATA_BITS'(7);
      full_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.finish;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PROBE_MODE: mode_r  <= cfg_wdata[0];
          CFG_TABLE_SIZE: tsize_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.finish && cmd.code != ST_DROP) full_r[slot_sel] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r     <= in_key;
      be_r      <= in_batch_end;
      div_sh_r  <= DIV_BITS'(in_key);
      div_cnt_r <= '0;
      rem_r     <= '0;
    end else if (cmd.div_step) begin
      div_sh_r  <= div_sh_r << 2;
      div_cnt_r <= div_cnt_r + DIV_CNT_BITS'(1);
      rem_r     <= r2[SLOT_BITS-1:0];
    end
    if (cmd.probe_init) begin
      idx_r <= rem_r;
      inc_r <= inc_init[SLOT_BITS-1:0];
      j_r   <= SIZE_BITS'(1);
    end else if (cmd.probe_step) begin
      // quadratic mode: successive squares differ by 2j-1, kept mod n; linear mode keeps the step
      idx_r <= cand[SLOT_BITS-1:0];
      if (mode_r) inc_r <= inc2[SLOT_BITS-1:0];
      j_r   <= j_r + SIZE_BITS'(1);
    end
    if (cmd.finish) begin
      status_r <= cmd.code;
      slot_r   <= slot_sel;
      be_out_r <= be_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && cmd.code != ST_DROP) slot_keys_mem[slot_sel] <= key_r;
  end

  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_slot          = slot_r;
  assign out_batch_end_out = be_out_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && cmd.code != ST_DROP |-> !full_r[slot_sel])
    else $error("insert into occupied slot");

  a_slot_marked: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && cmd.code != ST_DROP |=> full_r[slot_r])
    else $error("written slot not marked full");

  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |=> !strobe_r)
    else $error("result strobe longer than one beat");

  a_home_slot: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r && status_r == ST_HOME |-> slot_r == rem_r)
    else $error("home result slot differs from remainder");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> {1'b0, slot_r} < n_act)
    else $error("result slot outside active table");

endmodule

[sv/open_addressing_hash_insert_core.sv]
// Open-addressing hash insert.
// Input: start with in_key / in_batch_end; a beat is taken on a rising edge
// with start high and busy low. busy stays high until the result is issued.
// Output: out_strobe is high for exactly one cycle with out_status (0 home,
// 1 placed after probing, 2 dropped), out_slot (0 when dropped) and
// out_batch_end_out. The receiver cannot stall; the result must be taken.
// Config: cfg_we writes cfg_wdata to register cfg_index (0 probe mode,
// 1 table size); write only while busy is low.
// Operation: the home slot (key mod size) comes from a two-bit-per-cycle
// remainder unit; the home slot is then checked and, if it is full, further
// slots are probed with the shared probe adder, up to size-1 probes.
// One key is in flight at a time; a new key can be taken on the edge that
// ends the strobe cycle.
// Reset: all slots empty, probe mode linear, table size 7.
module open_addressing_hash_insert_core
  import oah_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [KEY_BITS-1:0]      in_key,
  input  logic                     in_batch_end,
  output logic                     out_strobe,
  output logic [1:0]               out_status,
  output logic [SLOT_BITS-1:0]     out_slot,
  output logic                     out_batch_end_out,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  oah_cmd_t  cmd;
  oah_stat_t stat;

  oah_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  oah_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_key            (in_key),
    .in_batch_end      (in_batch_end),
    .cmd               (cmd),
    .stat              (stat),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_batch_end_out (out_batch_end_out)
  );

endmodule
